FILE: hw/rtl/static_arithmetic_encoder_core_defines.svh
// Assertion macros for the static arithmetic encoder core.
// Depends on nothing; define ASSERT_OFF to compile all checks away.
`ifndef STATIC_ARITHMETIC_ENCODER_CORE_DEFINES_SVH
`define STATIC_ARITHMETIC_ENCODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define SAE_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sae assertion failed");
// Check that a condition never holds outside reset.
`define SAE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("sae condition must never hold");
`else
`define SAE_ASSERT(lbl, clk, rst_n, prop)
`define SAE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

FILE: hw/rtl/sae_pkg.sv
// Shared constants and types of the static arithmetic encoder.
// Depends on nothing.
package sae_pkg;

	localparam int SYM_COUNT    = 257;
	localparam int CODE_BITS    = 32;
	localparam int COUNT_BITS   = 22;
	localparam int FOLLOW_LIMIT = 255;
	localparam int MAX_RES      = 40;
	localparam int SUM_BITS     = 31;
	localparam int CUM_AW       = $clog2(SYM_COUNT + 1);
	localparam int RES_AW       = $clog2(MAX_RES + 1);

	localparam logic [CODE_BITS-1:0] QUARTER   = CODE_BITS'(64'd1 << (CODE_BITS - 2));
	localparam logic [CODE_BITS-1:0] HALF_PT   = CODE_BITS'(64'd1 << (CODE_BITS - 1));
	localparam logic [CODE_BITS-1:0] THREE_QTR = CODE_BITS'(64'd3 << (CODE_BITS - 2));

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_ENCODE = 2'd1,
		REQ_FINISH = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_CNT = 2'd1,
		ST_OVERFLOW = 2'd2,
		ST_UNUSED   = 2'd3
	} status_t;

endpackage

FILE: hw/rtl/sae_in_if.sv
// Request channel of the encoder: valid/ready plus one request word.
// Depends on sae_pkg.
interface sae_in_if;
	import sae_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [1:0]            req_type;
	logic [7:0]            symbol;
	logic [COUNT_BITS-1:0] sym_count;

	modport source (output valid, output req_type, output symbol, output sym_count,
		input ready);
	modport sink (input valid, input req_type, input symbol, input sym_count,
		output ready);
endinterface

FILE: hw/rtl/sae_out_if.sv
// Result channel of the encoder: valid/ready plus one code byte word.
// Depends on sae_pkg.
interface sae_out_if;
	import sae_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic [1:0] status;

	modport source (output valid, output out_byte, output last, output status,
		input ready);
	modport sink (input valid, input out_byte, input last, input status,
		output ready);
endinterface

FILE: hw/rtl/static_arithmetic_encoder_core.sv
// Channel  Dir  Word                               Accepted when
// req      in   req_type, symbol, sym_count        req.valid && req.ready
// rsp      out  out_byte, last, status             rsp.valid && rsp.ready
//
// One request at a time. Encode runs two 64-step restoring divisions, then
// the renormalisation steps, packing each emitted code bit and then its
// pending bits into the byte buffer, and then hands out the result bytes.
// Finish adds the closing bit, its pending bits and the partial byte.
// Reset clears the coder registers; the count table memory is not cleared.
// A waiting result word does not block the next request.
//
// Depends on sae_pkg, sae_in_if, sae_out_if and the defines header.
`include "static_arithmetic_encoder_core_defines.svh"

module static_arithmetic_encoder_core (
	input logic clk,
	input logic arst_n,
	sae_in_if.sink req,
	sae_out_if.source rsp
);
	import sae_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE     = 19'h00001,
		S_LOAD     = 19'h00002,
		S_RD_LO    = 19'h00004,
		S_RD_HI    = 19'h00008,
		S_CHK      = 19'h00010,
		S_MUL_A    = 19'h00020,
		S_MUL_B    = 19'h00040,
		S_DIV_INIT = 19'h00080,
		S_DIV      = 19'h00100,
		S_DIV_END  = 19'h00200,
		S_REN      = 19'h00400,
		S_EMIT     = 19'h00800,
		S_FOL      = 19'h01000,
		S_CLOSE    = 19'h02000,
		S_FLUSH    = 19'h04000,
		S_DONE     = 19'h08000,
		S_FLAG     = 19'h10000,
		S_DRN_RD   = 19'h20000,
		S_DRN_LD   = 19'h40000
	} state_t;

	state_t state_q;

	// request word
	logic [1:0]            req_q;
	logic [7:0]            sym_q;
	logic [COUNT_BITS-1:0] cnt_q;

	// coder state
	logic [SUM_BITS-1:0]  sum_q;
	logic [CODE_BITS-1:0] low_q, high_q, new_hi_q;
	logic [7:0]           fol_q;
	logic [7:0]           buf_q;
	logic [2:0]           fill_q;

	// arithmetic
	logic [31:0] lo_c_q, hi_c_q;
	logic        sel_lo_q;
	logic [63:0] rng_q, p0_q, dq_q;
	logic [31:0] p1_q, rem_q;
	logic [5:0]  div_cnt_q;
	logic [5:0]  step_q;
	logic        bit_q;
	logic        ret_fin_q;

	// per-request result bookkeeping
	logic [RES_AW-1:0] n_q, drn_idx_q;
	logic              ovf_q;
	logic [1:0]        stat_q;

	// output register
	logic       ov_q;
	logic [7:0] ob_q;
	logic       ol_q;
	logic [1:0] os_q;

	// memories
	logic [SUM_BITS-1:0] cum_mem [0:SYM_COUNT];
	logic [SUM_BITS-1:0] cum_rd_q;
	logic [CUM_AW-1:0]   cum_raddr;
	logic [7:0]          byte_mem [0:MAX_RES-1];
	logic [7:0]          byte_rd_q;

	logic                 accept, out_free, out_load;
	logic [31:0]          total, c_sel;
	logic [63:0]          prod_lo;
	logic [31:0]          prod_hi;
	logic [32:0]          div_r;
	logic                 div_ge;
	logic [63:0]          rng_now;
	logic                 pk_en, pk_bit;
	logic [7:0]           pk_buf;
	logic                 push;
	logic [7:0]           push_byte;
	logic                 sym_ok;
	logic [1:0]           fin_stat;

	assign accept   = req.valid && req.ready;
	assign out_free = !ov_q || rsp.ready;
	assign out_load = out_free && ((state_q == S_FLAG) || (state_q == S_DRN_LD));
	assign total    = 32'(sum_q) + 32'd1;
	assign c_sel    = sel_lo_q ? lo_c_q : hi_c_q;
	assign prod_lo  = 64'(rng_q[31:0]) * 64'(c_sel);
	assign prod_hi  = 32'(rng_q[63:32] * c_sel);
	assign div_r    = {rem_q, dq_q[63]};
	assign div_ge   = div_r >= {1'b0, total};
	assign rng_now  = 64'(high_q) - 64'(low_q) + 64'd1;
	assign sym_ok   = 32'(sym_q) < (SYM_COUNT - 1);
	assign fin_stat = (stat_q != ST_OK) ? stat_q : (ovf_q ? ST_OVERFLOW : ST_OK);

	// Pack one code bit into the byte buffer.
	always_comb begin
		pk_en  = (state_q == S_EMIT) || ((state_q == S_FOL) && (fol_q != 8'd0));
		pk_bit = bit_q;
		pk_buf = buf_q | ({7'd0, pk_bit} << (3'd7 - fill_q));
	end

	// Select the byte going to the result store.
	always_comb begin
		push      = 1'b0;
		push_byte = pk_buf;
		if (pk_en && (fill_q == 3'd7)) begin
			push = 1'b1;
		end else if ((state_q == S_FLUSH) && (fill_q != 3'd0)) begin
			push      = 1'b1;
			push_byte = buf_q;
		end
	end

	// Count table read address.
	always_comb begin
		case (state_q)
			S_RD_HI: cum_raddr = CUM_AW'(sym_q) + CUM_AW'(1);
			default: cum_raddr = CUM_AW'(sym_q);
		endcase
	end

	// Count table memory.
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD && sym_ok) begin
			cum_mem[CUM_AW'(sym_q) + CUM_AW'(1)] <=
				(sym_q == 8'd0) ? SUM_BITS'(cnt_q) : sum_q + SUM_BITS'(cnt_q);
		end
		cum_rd_q <= cum_mem[cum_raddr];
	end

	// Result byte store.
	always_ff @(posedge clk) begin
		if (push && (n_q < RES_AW'(MAX_RES))) begin
			byte_mem[n_q] <= push_byte;
		end
		byte_rd_q <= byte_mem[drn_idx_q];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req.req_type;
			sym_q <= req.symbol;
			cnt_q <= req.sym_count;
		end
		case (state_q)
			S_IDLE: begin
				if (accept && req.req_type == REQ_FINISH) begin
					lo_c_q <= 32'(sum_q);
					hi_c_q <= 32'(sum_q) + 32'd1;
					rng_q  <= rng_now;
				end
			end
			S_RD_HI: lo_c_q <= (sym_q == 8'd0) ? 32'd0 : 32'(cum_rd_q);
			S_CHK: begin
				hi_c_q <= 32'(cum_rd_q);
				rng_q  <= rng_now;
			end
			S_MUL_A: p0_q <= prod_lo;
			S_MUL_B: p1_q <= prod_hi;
			S_DIV_INIT: begin
				dq_q  <= p0_q + {p1_q, 32'd0};
				rem_q <= 32'd0;
			end
			S_DIV: begin
				dq_q  <= {dq_q[62:0], div_ge};
				rem_q <= div_ge ? 32'(div_r - {1'b0, total}) : div_r[31:0];
			end
			S_DIV_END: begin
				if (!sel_lo_q) begin
					new_hi_q <= low_q + dq_q[CODE_BITS-1:0] - CODE_BITS'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Control and coder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sum_q     <= '0;
			low_q     <= '0;
			high_q    <= '1;
			fol_q     <= '0;
			buf_q     <= '0;
			fill_q    <= '0;
			sel_lo_q  <= 1'b0;
			div_cnt_q <= '0;
			step_q    <= '0;
			bit_q     <= 1'b0;
			ret_fin_q <= 1'b0;
			n_q       <= '0;
			drn_idx_q <= '0;
			ovf_q     <= 1'b0;
			stat_q    <= ST_OK;
			ov_q      <= 1'b0;
			ob_q      <= '0;
			ol_q      <= 1'b0;
			os_q      <= ST_OK;
		end else begin
			if (ov_q && rsp.ready && !out_load) begin
				ov_q <= 1'b0;
			end
			if (pk_en) begin
				buf_q  <= (fill_q == 3'd7) ? 8'd0 : pk_buf;
				fill_q <= fill_q + 3'd1;
			end
			if (push && (n_q < RES_AW'(MAX_RES))) begin
				n_q <= n_q + RES_AW'(1);
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q       <= '0;
						drn_idx_q <= '0;
						ovf_q     <= 1'b0;
						stat_q    <= ST_OK;
						sel_lo_q  <= 1'b0;
						ret_fin_q <= 1'b0;
						case (req.req_type)
							REQ_LOAD:   state_q <= S_LOAD;
							REQ_ENCODE: state_q <= S_RD_LO;
							REQ_FINISH: state_q <= S_MUL_A;
							default:    state_q <= S_DONE;
						endcase
					end
				end
				S_LOAD: begin
					if (sym_ok) begin
						sum_q <= (sym_q == 8'd0) ? SUM_BITS'(cnt_q) : sum_q + SUM_BITS'(cnt_q);
					end
					state_q <= S_IDLE;
				end
				S_RD_LO: state_q <= S_RD_HI;
				S_RD_HI: state_q <= S_CHK;
				S_CHK: begin
					// reject an invalid symbol or one whose count range is empty or ends beyond the total
					if (!sym_ok || (32'(cum_rd_q) <= lo_c_q) || (cum_rd_q > sum_q)) begin
						stat_q  <= ST_ZERO_CNT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_MUL_A;
					end
				end
				S_MUL_A: state_q <= S_MUL_B;
				S_MUL_B: state_q <= S_DIV_INIT;
				S_DIV_INIT: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd63) begin
						state_q <= S_DIV_END;
					end
				end
				S_DIV_END: begin
					if (!sel_lo_q) begin
						sel_lo_q <= 1'b1;
						state_q  <= S_MUL_A;
					end else begin
						low_q   <= low_q + dq_q[CODE_BITS-1:0];
						high_q  <= new_hi_q;
						step_q  <= '0;
						state_q <= S_REN;
					end
				end
				S_REN: begin
					// one renormalisation step, bounded by the code width
					if (32'(step_q) >= CODE_BITS) begin
						state_q <= (req_q == REQ_FINISH) ? S_CLOSE : S_DONE;
					end else if (high_q < HALF_PT) begin
						bit_q   <= 1'b0;
						low_q   <= low_q << 1;
						high_q  <= (high_q << 1) | CODE_BITS'(1);
						step_q  <= step_q + 6'd1;
						state_q <= S_EMIT;
					end else if (low_q >= HALF_PT) begin
						bit_q   <= 1'b1;
						low_q   <= (low_q - HALF_PT) << 1;
						high_q  <= ((high_q - HALF_PT) << 1) | CODE_BITS'(1);
						step_q  <= step_q + 6'd1;
						state_q <= S_EMIT;
					end else if ((low_q >= QUARTER) && (high_q < THREE_QTR)) begin
						if (32'(fol_q) >= FOLLOW_LIMIT) begin
							ovf_q <= 1'b1;
						end else begin
							fol_q <= fol_q + 8'd1;
						end
						low_q  <= (low_q - QUARTER) << 1;
						high_q <= ((high_q - QUARTER) << 1) | CODE_BITS'(1);
						step_q <= step_q + 6'd1;
					end else begin
						state_q <= (req_q == REQ_FINISH) ? S_CLOSE : S_DONE;
					end
				end
				S_EMIT: begin
					bit_q   <= ~bit_q;
					state_q <= S_FOL;
				end
				S_FOL: begin
					// drain pending opposite bits
					if (fol_q == 8'd0) begin
						state_q <= ret_fin_q ? S_FLUSH : S_REN;
					end else begin
						fol_q <= fol_q - 8'd1;
					end
				end
				S_CLOSE: begin
					if (32'(fol_q) >= FOLLOW_LIMIT) begin
						ovf_q <= 1'b1;
					end else begin
						fol_q <= fol_q + 8'd1;
					end
					bit_q     <= (low_q < QUARTER) ? 1'b0 : 1'b1;
					ret_fin_q <= 1'b1;
					state_q   <= S_EMIT;
				end
				S_FLUSH: begin
					low_q   <= '0;
					high_q  <= '1;
					fol_q   <= '0;
					buf_q   <= '0;
					fill_q  <= '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					stat_q <= fin_stat;
					if (n_q == '0) begin
						state_q <= (fin_stat != ST_OK) ? S_FLAG : S_IDLE;
					end else begin
						state_q <= S_DRN_RD;
					end
				end
				S_FLAG: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						ob_q    <= 8'd0;
						ol_q    <= 1'b1;
						os_q    <= stat_q;
						state_q <= S_IDLE;
					end
				end
				S_DRN_RD: state_q <= S_DRN_LD;
				S_DRN_LD: begin
					// hand the next stored byte to the output register
					if (out_free) begin
						ov_q <= 1'b1;
						ob_q <= byte_rd_q;
						ol_q <= (drn_idx_q == n_q - RES_AW'(1));
						os_q <= stat_q;
						if (drn_idx_q == n_q - RES_AW'(1)) begin
							state_q <= S_IDLE;
						end else begin
							drn_idx_q <= drn_idx_q + RES_AW'(1);
							state_q   <= S_DRN_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready    = (state_q == S_IDLE);
	assign rsp.valid    = ov_q;
	assign rsp.out_byte = ob_q;
	assign rsp.last     = ol_q;
	assign rsp.status   = os_q;

	`SAE_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> !req.ready)
	`SAE_ASSERT(a_no_req_mid_msg, clk, arst_n, (ov_q && !ol_q) |-> !req.ready)
	`SAE_ASSERT(a_div_rem_bound, clk, arst_n, (state_q == S_DIV) |-> (rem_q < total))
	`SAE_ASSERT_NEVER(a_res_count, clk, arst_n, n_q > RES_AW'(MAX_RES))

endmodule

FILE: bench/tb_static_arithmetic_encoder_core.sv
// Self-checking bench for static_arithmetic_encoder_core: directed table, then random
// count tables, encode runs and finishes, checked against a cycle-free encoder model.
// Depends on sae_pkg, sae_in_if, sae_out_if and the core RTL.
module tb_static_arithmetic_encoder_core;
	import sae_pkg::*;

	typedef struct packed {
		logic [7:0] code;
		logic       fin;
		status_t    st;
	} code_word_t;

	typedef struct {
		req_t        rt;
		logic [7:0]  sym;
		logic [21:0] cnt;
		bit          typed;
		code_word_t  want;
	} stim_row_t;

	localparam logic [63:0] CODE_MASK = 64'hFFFF_FFFF;
	localparam logic [63:0] Q_PT = {32'd0, QUARTER};
	localparam logic [63:0] H_PT = {32'd0, HALF_PT};
	localparam logic [63:0] T_PT = {32'd0, THREE_QTR};
	localparam int SETTLE_CYCLES = 600;

	logic clk;
	logic arst_n;

	sae_in_if  req_if();
	sae_out_if rsp_if();

	static_arithmetic_encoder_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// encoder model state
	logic [30:0] cum_mem [0:256];
	bit          cum_set [0:256];
	logic [30:0] run_sum;
	logic [63:0] lo_b, hi_b;
	int unsigned pend_bits;
	logic [7:0]  acc_byte;
	int unsigned acc_n;
	logic [7:0]  item_bytes [$];
	bit          item_ovf;

	code_word_t  code_q [$];
	stim_row_t   dir_rows [$];
	int          n_err;
	int          n_items;
	int          rx_count;
	int          cyc;
	bit          tx_calm;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cyc <= cyc + 1;

	function automatic void put_bit(bit b);
		if (b)
			acc_byte[7 - acc_n] = 1'b1;
		acc_n++;
		if (acc_n == 8) begin
			if (item_bytes.size() < MAX_RES)
				item_bytes.push_back(acc_byte);
			acc_byte = '0;
			acc_n = 0;
		end
	endfunction

	function automatic void put_with_pending(bit b);
		put_bit(b);
		while (pend_bits > 0) begin
			put_bit(!b);
			pend_bits--;
		end
	endfunction

	function automatic void bump_pending();
		if (pend_bits >= FOLLOW_LIMIT)
			item_ovf = 1'b1;
		else
			pend_bits++;
	endfunction

	// Narrow the interval to [lo_c, hi_c) of total, then renormalize.
	function automatic void narrow_scale(logic [63:0] lo_c, logic [63:0] hi_c,
		logic [63:0] total);
		logic [63:0] span;
		logic [63:0] base;
		span = hi_b - lo_b + 64'd1;
		base = lo_b;
		hi_b = (base + (span * hi_c) / total - 64'd1) & CODE_MASK;
		lo_b = (base + (span * lo_c) / total) & CODE_MASK;
		for (int k = 0; k < CODE_BITS; k++) begin
			if (hi_b < H_PT) begin
				put_with_pending(1'b0);
			end else if (lo_b >= H_PT) begin
				put_with_pending(1'b1);
				lo_b = lo_b - H_PT;
				hi_b = hi_b - H_PT;
			end else if (lo_b >= Q_PT && hi_b < T_PT) begin
				bump_pending();
				lo_b = lo_b - Q_PT;
				hi_b = hi_b - Q_PT;
			end else begin
				break;
			end
			lo_b = (lo_b << 1) & CODE_MASK;
			hi_b = ((hi_b << 1) | 64'd1) & CODE_MASK;
		end
	endfunction

	function automatic void clear_coder();
		lo_b = '0;
		hi_b = CODE_MASK;
		pend_bits = 0;
		acc_byte = '0;
		acc_n = 0;
	endfunction

	// Work out the code words that one accepted request produces.
	function automatic void predict_codes(req_t rt, logic [7:0] sym, logic [21:0] cnt,
		ref code_word_t words [$]);
		status_t     st;
		logic [63:0] lo_c, hi_c, total;
		st = ST_OK;
		item_bytes.delete();
		item_ovf = 1'b0;
		words.delete();
		case (rt)
			REQ_LOAD: begin
				if (sym == 8'd0)
					run_sum = 31'(cnt);
				else
					run_sum = run_sum + 31'(cnt);
				cum_mem[sym + 1] = run_sum;
				cum_set[sym + 1] = 1'b1;
				return;
			end
			REQ_ENCODE: begin
				lo_c = {33'd0, cum_mem[sym]};
				hi_c = {33'd0, cum_mem[sym + 1]};
				if (hi_c <= lo_c || hi_c > {33'd0, run_sum})
					st = ST_ZERO_CNT;
				else
					narrow_scale(lo_c, hi_c, {33'd0, run_sum} + 64'd1);
			end
			REQ_FINISH: begin
				total = {33'd0, run_sum} + 64'd1;
				narrow_scale({33'd0, run_sum}, total, total);
				bump_pending();
				put_with_pending(lo_b < Q_PT ? 1'b0 : 1'b1);
				if (acc_n > 0 && item_bytes.size() < MAX_RES)
					item_bytes.push_back(acc_byte);
				clear_coder();
			end
			default: return;
		endcase
		if (st == ST_OK && item_ovf)
			st = ST_OVERFLOW;
		if (st != ST_OK && item_bytes.size() == 0) begin
			words.push_back('{code: 8'd0, fin: 1'b1, st: st});
			return;
		end
		foreach (item_bytes[i])
			words.push_back('{code: item_bytes[i], fin: (i == item_bytes.size() - 1),
				st: st});
	endfunction

	// Offer one request word, hold it until accepted, queue its code words.
	task automatic send_req(req_t rt, logic [7:0] sym, logic [21:0] cnt, bit typed,
		code_word_t want);
		code_word_t words [$];
		while (!tx_calm && $urandom_range(99) < 16) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.req_type  <= rt;
		req_if.symbol    <= sym;
		req_if.sym_count <= cnt;
		do @(posedge clk); while (!req_if.ready);
		predict_codes(rt, sym, cnt, words);
		if (typed) begin
			words.delete();
			words.push_back(want);
		end
		foreach (words[i])
			code_q.push_back(words[i]);
		n_items++;
	endtask

	function automatic void add_row(req_t rt, logic [7:0] sym, logic [21:0] cnt);
		dir_rows.push_back('{rt: rt, sym: sym, cnt: cnt, typed: 1'b0, want: '0});
	endfunction

	// Symbols whose both table entries hold a written count.
	function automatic void legal_syms(ref int syms [$]);
		syms.delete();
		for (int s = 0; s < 256; s++)
			if ((s == 0 || cum_set[s]) && cum_set[s + 1])
				syms.push_back(s);
	endfunction

	function automatic logic [21:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 22'd0;
		if (r < 15)
			return 22'h3F_FFFF;
		if (r < 30)
			return 22'($urandom);
		return 22'($urandom_range(1, 2000));
	endfunction

	// Check each accepted code word against the oldest expectation.
	always @(posedge clk) begin
		code_word_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			rx_count <= rx_count + 1;
			if (code_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected word: byte %h last %b status %0d",
						rsp_if.out_byte, rsp_if.last, rsp_if.status);
			end else begin
				want = code_q.pop_front();
				if (rsp_if.out_byte !== want.code || rsp_if.last !== want.fin ||
					rsp_if.status !== want.st) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: want %h/%b/%0d got %h/%b/%0d",
							want.code, want.fin, want.st, rsp_if.out_byte,
							rsp_if.last, rsp_if.status);
				end
			end
		end
	end

	// Drive result ready: random stalls, a calm window, one long hold-off.
	int  hold_left;
	bit  hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_if.ready <= 1'b0;
		end else if (!hold_done && rx_count >= 60) begin
			hold_done <= 1'b1;
			hold_left <= 3000;
			rsp_if.ready <= 1'b0;
		end else if (cyc > 30000 && cyc < 45000) begin
			rsp_if.ready <= 1'b1;
		end else begin
			rsp_if.ready <= ($urandom_range(99) >= 16);
		end
	end

	initial begin
		#4000000;
		$display("tb_static_arithmetic_encoder_core: FAIL");
		$finish;
	end

	initial begin
		int          syms [$];
		int          nxt, n_enc, rep;
		logic [21:0] mid;
		req_if.valid = 1'b0;
		req_if.req_type = REQ_NONE;
		req_if.symbol = '0;
		req_if.sym_count = '0;
		arst_n = 1'b0;
		cyc = 0;
		n_err = 0;
		n_items = 0;
		rx_count = 0;
		tx_calm = 1'b0;
		for (int i = 0; i <= 256; i++) begin
			cum_mem[i] = '0;
			cum_set[i] = 1'b0;
		end
		run_sum = '0;
		clear_coder();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme counts, a zero-count symbol, a tiny symbol in the
		// middle of the range so pending bits pile up to the limit, then finish.
		add_row(REQ_LOAD, 8'd0, 22'd0);
		add_row(REQ_LOAD, 8'd1, 22'h3F_FFFF);
		add_row(REQ_LOAD, 8'd2, 22'd1);
		add_row(REQ_LOAD, 8'd3, 22'h3F_FFFF);
		dir_rows.push_back('{rt: REQ_ENCODE, sym: 8'd0, cnt: 22'd0, typed: 1'b1,
			want: '{code: 8'd0, fin: 1'b1, st: ST_ZERO_CNT}});
		add_row(REQ_ENCODE, 8'd1, 22'h3F_FFFF);
		repeat (14) add_row(REQ_ENCODE, 8'd2, 22'd0);
		add_row(REQ_FINISH, 8'hFF, 22'h2A_AAAA);
		add_row(REQ_NONE, 8'hFF, 22'h3F_FFFF);
		add_row(REQ_LOAD, 8'd255, 22'h15_5555);
		add_row(REQ_ENCODE, 8'd3, 22'd0);
		add_row(REQ_FINISH, 8'd0, 22'd0);
		foreach (dir_rows[i])
			send_req(dir_rows[i].rt, dir_rows[i].sym, dir_rows[i].cnt,
				dir_rows[i].typed, dir_rows[i].want);

		// Random: a fresh partial count table, an encode run with stray load or no-op requests, then mostly a finish.
		while (n_items < 330) begin
			tx_calm = (n_items >= 170 && n_items < 240);
			send_req(REQ_LOAD, 8'd0, pick_count(), 1'b0, '0);
			nxt = 0;
			repeat ($urandom_range(2, 7)) begin
				nxt = nxt + $urandom_range(1, 45);
				if (nxt <= 255)
					send_req(REQ_LOAD, 8'(nxt), pick_count(), 1'b0, '0);
			end
			legal_syms(syms);
			n_enc = $urandom_range(4, 22);
			rep = ($urandom_range(9) == 0) ? syms[$urandom_range(syms.size() - 1)] : -1;
			for (int k = 0; k < n_enc; k++) begin
				if ($urandom_range(19) == 0) begin
					mid = 22'($urandom);
					send_req(($urandom_range(1) ? REQ_NONE : REQ_LOAD), 8'($urandom),
						mid, 1'b0, '0);
					legal_syms(syms);
				end
				send_req(REQ_ENCODE,
					8'(rep >= 0 ? rep : syms[$urandom_range(syms.size() - 1)]),
					22'($urandom), 1'b0, '0);
			end
			if ($urandom_range(5) != 0)
				send_req(REQ_FINISH, 8'($urandom), 22'($urandom), 1'b0, '0);
		end
		send_req(REQ_FINISH, 8'd0, 22'd0, 1'b0, '0);
		req_if.valid <= 1'b0;

		while (code_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (n_err == 0 && code_q.size() == 0)
			$display("tb_static_arithmetic_encoder_core: PASS");
		else
			$display("tb_static_arithmetic_encoder_core: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/sae_pkg.sv
hw/rtl/sae_in_if.sv
hw/rtl/sae_out_if.sv
hw/rtl/static_arithmetic_encoder_core.sv
bench/tb_static_arithmetic_encoder_core.sv
